[rtl/core/dth_pkg.sv]
`timescale 1ns / 1ps
// Package for the deadline timer heap: request and response transfer types,
// request and status codes and the result limit of one tick.
// Depends on nothing.
package dth_pkg;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam int MAX_RESULTS = 32;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] deadline_ms;
    logic [31:0] user_tag;
    logic [31:0] cancel_id;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [31:0] timer_id_out;
    logic [31:0] tag_out;
    logic        last;
  } rsp_t;

endpackage

[rtl/core/deadline_timer_heap.sv]
`timescale 1ns / 1ps
// Top level of the deadline timer heap: a binary min-heap of timers in one
// memory, driven by a small sequencer. Depends on dth_pkg.
//
// The block takes one request at a time and is not ready until its last
// response transfer has been loaded into the output register. Every heap
// step is a memory read followed by a compare and a write. An add sifts the
// new timer up level by level, a cancel reads every stored timer in turn,
// and a tick removes due timers from the root one at a time, sifting down
// after each; a stall on the response side holds any of them. A tick
// returns at most 32 fired timers; further due timers stay stored for the
// next tick. Deadlines are ordered by time and then by timer id. The heap
// memory needs no clearing after reset.
module deadline_timer_heap
  import dth_pkg::*;
#(
  parameter int HEAP_DEPTH = 32,
  parameter int TIME_WIDTH = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [TIME_WIDTH-1:0] dl;
    logic [31:0]           id;
    logic [31:0]           tag;
    logic                  canc;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_CAN_RD, S_CAN_CHK, S_T_RD, S_T_CHK,
    S_T_EMIT, S_DN_RD, S_DN_CMP, S_PUSH
  } state_t;

  function automatic logic entry_lt(entry_t a, entry_t b);
    logic r;
    if (a.dl != b.dl) begin
      r = a.dl < b.dl;
    end else begin
      r = a.id < b.id;
    end
    return r;
  endfunction

  state_t          state;
  logic [CW-1:0]   count;
  logic [31:0]     next_id;
  logic [IW-1:0]   pos;
  logic [IW-1:0]   idx;
  logic [NW-1:0]   n;
  entry_t          cur;
  logic [31:0]     cid;
  logic [TIME_WIDTH-1:0] now_r;
  logic [31:0]     pop_id;
  logic [31:0]     pop_tag;
  logic            pop_canc;
  rsp_t            res;

  entry_t          mem [HEAP_DEPTH];
  entry_t          rd_a;
  entry_t          rd_b;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  entry_t          mem_wd;
  logic [IW-1:0]   addr_a;
  logic [IW-1:0]   addr_b;

  logic [31:0]     id_inc;
  logic [IW-1:0]   parent;
  logic [IW+1:0]   lc;
  logic [IW+1:0]   rc;
  logic [IW+1:0]   cnt_ext;
  logic            sel_l;
  logic            sel_r;
  entry_t          best_l;
  logic            out_free;
  logic            rsp_load;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign id_inc    = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
  assign parent    = IW'((pos - IW'(1)) >> 1);
  assign lc        = {1'b0, pos, 1'b1};
  assign rc        = lc + (IW+2)'(1);
  assign cnt_ext   = (IW+2)'(count);
  assign sel_l     = entry_lt(rd_a, cur);
  assign best_l    = sel_l ? rd_a : cur;
  assign sel_r     = (rc < cnt_ext) && entry_lt(rd_b, best_l);
  assign rsp_load  = ((state == S_T_EMIT) && !pop_canc && res.fired && out_free) ||
                     ((state == S_PUSH) && out_free);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos;
    mem_wd = cur;
    addr_a = '0;
    addr_b = IW'(count - CW'(1));
    case (state)
      S_UP_RD: begin
        if (pos == '0) begin
          mem_we = 1'b1;
        end else begin
          addr_a = parent;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (entry_lt(cur, rd_a)) begin
          mem_wd = rd_a;
        end
      end
      S_CAN_RD: begin
        addr_a = idx;
      end
      S_CAN_CHK: begin
        if (rd_a.id == cid) begin
          mem_we      = 1'b1;
          mem_wa      = idx;
          mem_wd      = rd_a;
          mem_wd.canc = 1'b1;
        end
      end
      S_DN_RD: begin
        if (lc >= cnt_ext) begin
          mem_we = 1'b1;
        end else begin
          addr_a = lc[IW-1:0];
          addr_b = rc[IW-1:0];
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        mem_wd = sel_r ? rd_b : best_l;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      next_id   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur.dl      <= TIME_WIDTH'(req.deadline_ms);
            cur.id      <= id_inc;
            cur.tag     <= req.user_tag;
            cur.canc    <= 1'b0;
            cid         <= req.cancel_id;
            now_r       <= TIME_WIDTH'(req.now_ms);
            n           <= '0;
            idx         <= '0;
            res.fired   <= 1'b0;
            res.tag_out <= 32'd0;
            res.last    <= 1'b0;
            case (req.req_type)
              REQ_ADD: begin
                if (count == CW'(HEAP_DEPTH)) begin
                  res.status       <= ST_FULL;
                  res.timer_id_out <= 32'd0;
                  state            <= S_PUSH;
                end else begin
                  next_id          <= id_inc;
                  pos              <= IW'(count);
                  count            <= count + CW'(1);
                  res.status       <= ST_OK;
                  res.timer_id_out <= id_inc;
                  state            <= S_UP_RD;
                end
              end
              REQ_CANCEL: begin
                res.timer_id_out <= 32'd0;
                if (req.cancel_id == 32'd0) begin
                  res.status <= ST_INVALID;
                  state      <= S_PUSH;
                end else if (count == '0) begin
                  res.status <= ST_OK;
                  state      <= S_PUSH;
                end else begin
                  res.status <= ST_OK;
                  state      <= S_CAN_RD;
                end
              end
              REQ_TICK: begin
                res.status       <= ST_OK;
                res.timer_id_out <= 32'd0;
                state            <= S_T_RD;
              end
              default: begin
                res.status       <= ST_INVALID;
                res.timer_id_out <= 32'd0;
                state            <= S_PUSH;
              end
            endcase
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_PUSH : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (entry_lt(cur, rd_a)) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_PUSH;
          end
        end
        S_CAN_RD: begin
          state <= S_CAN_CHK;
        end
        S_CAN_CHK: begin
          idx <= idx + IW'(1);
          if (CW'(idx) + CW'(1) == count) begin
            state <= S_PUSH;
          end else begin
            state <= S_CAN_RD;
          end
        end
        S_T_RD: begin
          if (count == '0 || n == NW'(MAX_RESULTS)) begin
            state <= S_PUSH;
          end else begin
            state <= S_T_CHK;
          end
        end
        S_T_CHK: begin
          if (rd_a.dl <= now_r) begin
            pop_id   <= rd_a.id;
            pop_tag  <= rd_a.tag;
            pop_canc <= rd_a.canc;
            count    <= count - CW'(1);
            cur      <= rd_b;
            pos      <= '0;
            state    <= S_T_EMIT;
          end else begin
            state <= S_PUSH;
          end
        end
        S_T_EMIT: begin
          if (pop_canc || !res.fired || out_free) begin
            if (!pop_canc) begin
              n   <= n + NW'(1);
              res <= '{status: ST_OK, fired: 1'b1, timer_id_out: pop_id,
                       tag_out: pop_tag, last: 1'b0};
              if (res.fired) begin
                rsp <= res;
              end
            end
            state <= (count != '0) ? S_DN_RD : S_T_RD;
          end
        end
        S_DN_RD: begin
          state <= (lc >= cnt_ext) ? S_T_RD : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (sel_r) begin
            pos   <= rc[IW-1:0];
            state <= S_DN_RD;
          end else if (sel_l) begin
            pos   <= lc[IW-1:0];
            state <= S_DN_RD;
          end else begin
            state <= S_T_RD;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            rsp   <= '{status: res.status, fired: res.fired,
                       timer_id_out: res.timer_id_out, tag_out: res.tag_out,
                       last: 1'b1};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[test/tb_deadline_timer_heap.sv]
`timescale 1ns / 1ps
// Testbench for deadline_timer_heap: random and directed add, cancel and tick requests,
// with every response transfer checked against a heap scheduler kept in the scoreboard.
// Depends on dth_pkg and the deadline_timer_heap RTL.
module tb_deadline_timer_heap;
  import dth_pkg::*;

  localparam int HEAP_DEPTH = 32;
  localparam int TIME_WIDTH = 48;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 600;
  localparam int PHASE_ITEMS = 25;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [47:0] TIME_MAX = '1;

  class heap_scoreboard;
    logic [47:0] slot_deadline [HEAP_DEPTH];
    logic [31:0] slot_id [HEAP_DEPTH];
    logic [31:0] slot_tag [HEAP_DEPTH];
    bit slot_cancelled [HEAP_DEPTH];
    int count;
    logic [31:0] last_id;
    rsp_t awaited[$];
    int errors;
    int requests;
    int results;
    int fired_count;
    int full_count;

    function new();
      count = 0;
      last_id = '0;
      errors = 0;
      requests = 0;
      results = 0;
      fired_count = 0;
      full_count = 0;
    endfunction

    function bit earlier(int a, int b);
      if (slot_deadline[a] != slot_deadline[b]) begin
        return slot_deadline[a] < slot_deadline[b];
      end
      return slot_id[a] < slot_id[b];
    endfunction

    function void swap_slots(int a, int b);
      logic [47:0] d;
      logic [31:0] i;
      logic [31:0] t;
      bit c;
      d = slot_deadline[a];
      i = slot_id[a];
      t = slot_tag[a];
      c = slot_cancelled[a];
      slot_deadline[a] = slot_deadline[b];
      slot_id[a] = slot_id[b];
      slot_tag[a] = slot_tag[b];
      slot_cancelled[a] = slot_cancelled[b];
      slot_deadline[b] = d;
      slot_id[b] = i;
      slot_tag[b] = t;
      slot_cancelled[b] = c;
    endfunction

    function void sift_up(int pos);
      int parent;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (!earlier(pos, parent)) break;
        swap_slots(pos, parent);
        pos = parent;
      end
    endfunction

    function void sift_down(int pos);
      int l;
      int r;
      int best;
      forever begin
        l = 2 * pos + 1;
        r = l + 1;
        best = pos;
        if (l < count && earlier(l, best)) best = l;
        if (r < count && earlier(r, best)) best = r;
        if (best == pos) break;
        swap_slots(pos, best);
        pos = best;
      end
    endfunction

    function rsp_t make_rsp(logic [1:0] st, logic f, logic [31:0] id, logic [31:0] tag);
      rsp_t x;
      x.status = st;
      x.fired = f;
      x.timer_id_out = id;
      x.tag_out = tag;
      x.last = 1'b0;
      return x;
    endfunction

    function void accept_request(req_t r);
      rsp_t batch[$];
      int pos;
      logic [31:0] pid;
      logic [31:0] ptag;
      bit pc;
      requests++;
      case (r.req_type)
        REQ_ADD: begin
          if (count >= HEAP_DEPTH) begin
            batch.insert(batch.size(), make_rsp(ST_FULL, 1'b0, 32'd0, 32'd0));
            full_count++;
          end else begin
            last_id = last_id + 32'd1;
            if (last_id == 32'd0) last_id = 32'd1;
            pos = count;
            slot_deadline[pos] = r.deadline_ms;
            slot_id[pos] = last_id;
            slot_tag[pos] = r.user_tag;
            slot_cancelled[pos] = 1'b0;
            count++;
            sift_up(pos);
            batch.insert(batch.size(), make_rsp(ST_OK, 1'b0, last_id, 32'd0));
          end
        end
        REQ_CANCEL: begin
          if (r.cancel_id == 32'd0) begin
            batch.insert(batch.size(), make_rsp(ST_INVALID, 1'b0, 32'd0, 32'd0));
          end else begin
            for (pos = 0; pos < count; pos++) begin
              if (slot_id[pos] == r.cancel_id) slot_cancelled[pos] = 1'b1;
            end
            batch.insert(batch.size(), make_rsp(ST_OK, 1'b0, 32'd0, 32'd0));
          end
        end
        REQ_TICK: begin
          while (count > 0 && batch.size() < MAX_RESULTS &&
                 slot_deadline[0] <= r.now_ms) begin
            pid = slot_id[0];
            ptag = slot_tag[0];
            pc = slot_cancelled[0];
            count--;
            if (count > 0) begin
              swap_slots(0, count);
              sift_down(0);
            end
            if (!pc) begin
              batch.insert(batch.size(), make_rsp(ST_OK, 1'b1, pid, ptag));
              fired_count++;
            end
          end
          if (batch.size() == 0) begin
            batch.insert(batch.size(), make_rsp(ST_OK, 1'b0, 32'd0, 32'd0));
          end
        end
        default: begin
          batch.insert(batch.size(), make_rsp(ST_INVALID, 1'b0, 32'd0, 32'd0));
        end
      endcase
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) awaited.insert(awaited.size(), batch[k]);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      results++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: response transfer with none expected, expected none actual %h",
                 $time, got);
        return;
      end
      want = awaited.pop_front();
      compare("status", 32'(want.status), 32'(got.status));
      compare("fired", 32'(want.fired), 32'(got.fired));
      compare("timer_id_out", want.timer_id_out, got.timer_id_out);
      compare("tag_out", want.tag_out, got.tag_out);
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  heap_scoreboard sb;
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;
  logic [47:0] now_ms;
  int idle_send [4] = '{0, 77, 0, 24};
  int idle_recv [4] = '{0, 0, 77, 24};

  always #5 clk = ~clk;

  deadline_timer_heap #(
    .HEAP_DEPTH(HEAP_DEPTH),
    .TIME_WIDTH(TIME_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit", $time);
      $display("FAILED: results differ");
      $finish;
    end else if (!rst && rsp_valid && rsp_ready) begin
      sb.check_response(rsp);
    end
  end

  function logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function req_t scrambled();
    req_t r;
    r.req_type = 2'($urandom_range(3));
    r.deadline_ms = rand48();
    r.user_tag = $urandom();
    r.cancel_id = $urandom();
    r.now_ms = rand48();
    return r;
  endfunction

  task automatic send(req_t r);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.accept_request(r);
    @(negedge clk);
  endtask

  task automatic send_add(logic [47:0] dl, logic [31:0] tag);
    req_t r;
    r = scrambled();
    r.req_type = REQ_ADD;
    r.deadline_ms = dl;
    r.user_tag = tag;
    send(r);
  endtask

  task automatic send_cancel(logic [31:0] id);
    req_t r;
    r = scrambled();
    r.req_type = REQ_CANCEL;
    r.cancel_id = id;
    send(r);
  endtask

  task automatic tick(logic [47:0] t);
    req_t r;
    r = scrambled();
    r.req_type = REQ_TICK;
    r.now_ms = t;
    send(r);
  endtask

  task automatic unused_request();
    req_t r;
    r = scrambled();
    r.req_type = REQ_UNUSED;
    send(r);
  endtask

  task automatic fill_heap();
    while (sb.count < HEAP_DEPTH) send_add(now_ms + 48'($urandom_range(400)), $urandom());
    send_add(rand48(), $urandom());
    send_add(now_ms, $urandom());
    tick(TIME_MAX);
  endtask

  task automatic random_item();
    int pick;
    int sel;
    logic [47:0] dl;
    logic [31:0] id;
    pick = $urandom_range(99);
    sel = $urandom_range(19);
    if (pick < 45) begin
      if (sel == 0) dl = rand48();
      else if (sel == 1) dl = now_ms - 48'($urandom_range(50));
      else dl = now_ms + 48'($urandom_range(300));
      send_add(dl, $urandom());
    end else if (pick < 65) begin
      if (sel < 2) id = 32'd0;
      else if (sel < 4) id = $urandom();
      else id = sb.last_id - 32'($urandom_range(12));
      send_cancel(id);
    end else if (pick < 95) begin
      if (sel < 2) begin
        tick(TIME_MAX);
      end else begin
        now_ms = now_ms + 48'($urandom_range(150));
        tick(now_ms);
      end
    end else begin
      unused_request();
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    now_ms = 48'd1000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tick(48'd0);
    send_add(48'd0, 32'd0);
    send_add(TIME_MAX, 32'hFFFF_FFFF);
    send_add(48'd100, 32'hA5A5_0003);
    send_add(48'd100, 32'hA5A5_0004);
    send_add(48'd100, 32'hA5A5_0005);
    send_add(48'd50, 32'h1234_5678);
    send_cancel(32'd0);
    send_cancel(32'hFFFF_FFFF);
    send_cancel(32'd4);
    send_cancel(32'd4);
    unused_request();
    tick(48'd99);
    tick(48'd100);
    send_add(48'd200, 32'h5A5A_5A5A);
    send_cancel(32'd7);
    tick(48'd300);
    tick(TIME_MAX);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle = idle_send[phase];
      recv_stall = idle_recv[phase];
      if (phase == 1 || phase == 3) fill_heap();
      repeat (PHASE_ITEMS) random_item();
    end
    req_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d response transfers, %0d fired timers, %0d full refusals.",
             sb.requests, sb.results, sb.fired_count, sb.full_count);
    $display("Idling phases: none, sender 77%%, receiver 77%%, both 24%%.");
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[deadline_timer_heap.f]
rtl/core/dth_pkg.sv
rtl/core/deadline_timer_heap.sv
test/tb_deadline_timer_heap.sv
